### hw/rtl/adpcm_map_pkg.sv
// Package: shared types, codes and constants of the ADPCM memory access port.
package adpcm_map_pkg;

  localparam int unsigned ADDR_BITS_DEF = 18;
  localparam int unsigned DIVIDEND      = 72 * 65536;
  localparam int unsigned QUOT_BITS     = 23;
  localparam int unsigned DIV_BITS      = 17;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_HALT   = 3'd0,
    MODE_RECORD = 3'd1,
    MODE_REPLAY = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    START_NONE   = 2'd0,
    START_RECORD = 2'd1,
    START_REPLAY = 2'd2
  } start_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEM,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam logic [7:0] REG_CONTROL = 8'h00;
  localparam logic [7:0] REG_UNIT    = 8'h01;
  localparam logic [7:0] REG_START_L = 8'h02;
  localparam logic [7:0] REG_START_H = 8'h03;
  localparam logic [7:0] REG_STOP_L  = 8'h04;
  localparam logic [7:0] REG_STOP_H  = 8'h05;
  localparam logic [7:0] REG_PRE_L   = 8'h06;
  localparam logic [7:0] REG_PRE_H   = 8'h07;
  localparam logic [7:0] REG_DATA    = 8'h08;
  localparam logic [7:0] REG_DELTA_L = 8'h09;
  localparam logic [7:0] REG_DELTA_H = 8'h0a;
  localparam logic [7:0] REG_LIMIT_L = 8'h0c;
  localparam logic [7:0] REG_LIMIT_H = 8'h0d;
  localparam logic [7:0] REG_FLAGS   = 8'h10;

  localparam logic       CFG_READY_MASK = 1'b0;
  localparam logic       CFG_END_MASK   = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] bus_byte;
    logic       timer_flag_a;
    logic       timer_flag_b;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [1:0]  start_kind;
    logic [17:0] play_length;
    logic [22:0] rate_period;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/adpcm_map_div.sv
// Radix-2 restoring divider for the replay period (constant dividend).
module adpcm_map_div (
  input  logic                    clk,
  input  logic                    rst,
  input  adpcm_map_pkg::div_req_t req,
  output adpcm_map_pkg::div_rsp_t rsp
);
  import adpcm_map_pkg::*;

  localparam logic [QUOT_BITS-1:0] NUM = QUOT_BITS'(DIVIDEND);

  logic [DIV_BITS:0]    rem;
  logic [QUOT_BITS-1:0] quo;
  logic [DIV_BITS-1:0]  dsr;
  logic [4:0]           cnt;
  logic                 run;
  logic                 fin;
  logic [DIV_BITS:0]    trial;

  assign trial = {rem[DIV_BITS-1:0], NUM[cnt]};

  // one quotient bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      if (req.start) begin
        run <= 1'b1;
        fin <= 1'b0;
        cnt <= 5'(QUOT_BITS - 1);
        rem <= '0;
        dsr <= req.divisor;
      end else if (run) begin
        if (trial >= {1'b0, dsr}) begin
          rem      <= trial - {1'b0, dsr};
          quo[cnt] <= 1'b1;
        end else begin
          rem      <= trial;
          quo[cnt] <= 1'b0;
        end
        if (cnt == '0) begin
          run <= 1'b0;
          fin <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
          fin <= 1'b0;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  assign rsp = '{done: fin, quotient: quo};
endmodule

### hw/rtl/adpcm_map_mem.sv
// Sample memory: one synchronous port with a registered read.
module adpcm_map_mem #(
  parameter int unsigned ADDR_BITS = adpcm_map_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);
  logic [7:0] mem [2**ADDR_BITS];

  // write the addressed byte when we is high; the read is unconditional
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/adpcm_memory_access_port.sv
// Top level: ADPCM sample-memory access port with register file and sequencer.
//
// A request is taken when start is high and busy is low; its result appears on
// result with done high for exactly one cycle, and the receiver cannot stall
// it. Select, write, status and data read requests pass the memory and done
// states (the sample memory read issued in the memory state is captured in the
// done state); a delta-N pair write also waits on the one-bit-per-cycle divider
// of the replay period. The sample memory holds undefined data until written.
module adpcm_memory_access_port #(
  parameter int unsigned ADDR_BITS = adpcm_map_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  adpcm_map_pkg::req_t  request,
  output logic                 done,
  output adpcm_map_pkg::rsp_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);
  import adpcm_map_pkg::*;

  localparam logic [ADDR_BITS-1:0] AMASK = '1;

  state_t state, state_next;
  req_t   req;

  logic ready_mask, end_mask;
  logic [7:0] selected_register;
  logic [7:0] regs [16];
  logic [2:0] control_bits;
  mode_t access_mode;
  logic busy_flag, unit_is_large;
  logic [ADDR_BITS-1:0] start_address, stop_address, limit_address, data_pointer;
  logic [11:0] record_period;
  logic [22:0] replay_period;
  logic [1:0] dummy_reads_left, pending_flags;
  logic ready_flag, end_flag, end_notice;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_rdata;
  div_req_t             dreq;
  div_rsp_t             drsp;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);

  adpcm_map_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(req.bus_byte), .rdata(mem_rdata)
  );
  adpcm_map_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // decode of the captured request
  logic [7:0]  b;
  logic [15:0] pair_new;
  logic [3:0]  ridx;
  logic [ADDR_BITS+5:0] scaled, escaled;
  logic [15:0] prlo;
  logic [16:0] delta;
  logic is_wr, wr_data_mem;

  assign b     = req.bus_byte;
  assign ridx  = selected_register[3:0];
  assign is_wr = (op_t'(req.op) == OP_WRITE);
  assign wr_data_mem = is_wr && selected_register == REG_DATA && access_mode == MODE_WRITE;

  // pair value with the new byte merged in, and the addresses, period and divisor derived from it
  always_comb begin
    if (ridx[0] == 1'b1 ^ (ridx == 4'h9 || ridx == 4'ha) ^ 1'b0) pair_new = {b, 8'h00};
    else pair_new = '0;
    unique case (selected_register)
      REG_START_L: pair_new = {regs[3], b};
      REG_START_H: pair_new = {b, regs[2]};
      REG_STOP_L:  pair_new = {regs[5], b};
      REG_STOP_H:  pair_new = {b, regs[4]};
      REG_PRE_L:   pair_new = {regs[7], b};
      REG_PRE_H:   pair_new = {b, regs[6]};
      REG_DELTA_L: pair_new = {regs[10], b};
      REG_DELTA_H: pair_new = {b, regs[9]};
      REG_LIMIT_L: pair_new = {regs[13], b};
      REG_LIMIT_H: pair_new = {b, regs[12]};
      default:     pair_new = '0;
    endcase
    scaled  = unit_is_large ? ((ADDR_BITS+6)'(pair_new) << 5) : ((ADDR_BITS+6)'(pair_new) << 2);
    escaled = unit_is_large ? ((((ADDR_BITS+6)'(pair_new) + 1'b1) << 5) - 1'b1)
                            : ((((ADDR_BITS+6)'(pair_new) + 1'b1) << 2) - 1'b1);
    prlo    = pair_new & 16'h07ff;
    delta   = (pair_new == '0) ? 17'h10000 : {1'b0, pair_new};
  end

  // play length, wrap-aware
  logic [ADDR_BITS-1:0] len;
  always_comb begin
    if (stop_address == limit_address)
      len = (start_address < stop_address) ? stop_address - start_address : AMASK - start_address;
    else if (start_address < stop_address && start_address < limit_address)
      len = (stop_address < limit_address) ? stop_address - start_address : '0;
    else if (stop_address < start_address && stop_address < limit_address)
      len = (start_address < limit_address) ? limit_address - start_address + stop_address
                                            : AMASK - start_address;
    else
      len = (start_address < stop_address) ? stop_address - start_address : AMASK - start_address;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MEM;
      ST_MEM: begin
        if (is_wr && (selected_register == REG_DELTA_L || selected_register == REG_DELTA_H))
          state_next = ST_DIV;
        else state_next = ST_DONE;
      end
      ST_DIV:  if (drsp.done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port and divider launch
  logic rd_go;
  assign rd_go = op_t'(req.op) == OP_READ && selected_register == REG_DATA &&
                 access_mode == MODE_READ && dummy_reads_left == 2'd0 &&
                 data_pointer != stop_address;
  assign mem_addr = data_pointer;
  assign mem_we   = (state == ST_MEM) && wr_data_mem;
  assign dreq.start   = (state == ST_MEM) && state_next == ST_DIV;
  assign dreq.divisor = delta;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (start && state == ST_IDLE) req <= request;
  end

  // state update and result
  logic rd_pending;
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask <= 1'b0; end_mask <= 1'b0;
      selected_register <= 8'hff;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      control_bits <= '0; access_mode <= MODE_HALT; busy_flag <= 1'b0;
      unit_is_large <= 1'b1;
      start_address <= '0; stop_address <= '0; limit_address <= '0; data_pointer <= '0;
      record_period <= 12'd1; replay_period <= 23'd1;
      dummy_reads_left <= 2'd2; pending_flags <= '0;
      ready_flag <= 1'b0; end_flag <= 1'b0; end_notice <= 1'b0;
      done <= 1'b0; rd_pending <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
      if (cfg_valid) begin
        if (cfg_index == CFG_READY_MASK) ready_mask <= cfg_data;
        else end_mask <= cfg_data;
      end
      if (state == ST_MEM) begin
        rsp_t res;
        logic bf;
        res = '{read_value: 8'hff, start_kind: START_NONE, play_length: '0,
                rate_period: '0};
        bf = busy_flag;
        rd_pending <= rd_go;
        unique case (op_t'(req.op))
          OP_SELECT: selected_register <= b;
          OP_WRITE: begin
            if (selected_register < 8'h10) regs[ridx] <= b;
            priority case (selected_register)
              REG_CONTROL: begin
                control_bits <= b[0] ? {b[6], b[5], 1'b0} : {b[6], b[5], b[4]};
                if (busy_flag) begin
                  if (!b[5]) bf = 1'b0;
                end else if (b[5]) begin
                  if (b[7]) begin
                    access_mode <= b[6] ? MODE_RECORD : MODE_REPLAY;
                    res.start_kind  = b[6] ? START_RECORD : START_REPLAY;
                    res.rate_period = b[6] ? 23'(record_period) : replay_period;
                    res.play_length = 18'(len);
                    end_notice <= (len != '0);
                    bf = 1'b1;
                  end else begin
                    if (b[6]) begin
                      access_mode <= MODE_WRITE;
                      pending_flags[1] <= 1'b1;
                    end else begin
                      access_mode <= MODE_READ;
                      dummy_reads_left <= 2'd2;
                    end
                    data_pointer <= start_address;
                  end
                end
                if (b[0]) bf = 1'b0;
                busy_flag <= bf;
                if (!b[5]) access_mode <= MODE_HALT;
              end
              REG_UNIT: unit_is_large <= b[1];
              REG_START_L, REG_START_H: start_address <= scaled[ADDR_BITS-1:0];
              REG_STOP_L, REG_STOP_H: stop_address <= escaled[ADDR_BITS-1:0];
              REG_LIMIT_L, REG_LIMIT_H: limit_address <= escaled[ADDR_BITS-1:0];
              REG_PRE_L, REG_PRE_H:
                record_period <= (prlo == '0) ? 12'h800 : prlo[11:0];
              REG_DATA: if (access_mode == MODE_WRITE) begin
                pending_flags <= {1'b1, pending_flags[0] |
                                  (data_pointer == stop_address || data_pointer == AMASK)};
                data_pointer <= data_pointer + 1'b1;
              end
              REG_FLAGS: if (b[7]) begin
                ready_flag <= 1'b0; end_flag <= 1'b0;
              end
              default: ;
            endcase
          end
          OP_READ: if (selected_register == REG_DATA && access_mode == MODE_READ) begin
            if (dummy_reads_left != 2'd0) begin
              dummy_reads_left <= dummy_reads_left - 2'd1;
              if (data_pointer != stop_address) ready_flag <= !ready_mask;
            end else if (rd_go) begin
              data_pointer <= data_pointer + 1'b1;
              if ((data_pointer + 1'b1) != stop_address) ready_flag <= !ready_mask;
            end
          end
          OP_STATUS: begin
            logic rf, ef;
            rf = ready_flag; ef = end_flag;
            if (pending_flags[1] && !ready_mask) rf = 1'b1;
            if (pending_flags[0] && !end_mask)   ef = 1'b1;
            pending_flags <= '0;
            ready_flag <= rf; end_flag <= ef;
            res.read_value = {2'b00, busy_flag, 1'b0, rf, ef,
                              req.timer_flag_b, req.timer_flag_a};
          end
          default: ;
        endcase
        result <= res;
      end
      if (state == ST_DIV && drsp.done) replay_period <= drsp.quotient;
      if (state == ST_DONE) begin
        if (rd_pending) result.read_value <= mem_rdata;
      end
    end
  end

  logic unused;
  assign unused = ^{control_bits, end_notice};
endmodule
